/* hw/rtl/tblend_pkg.sv */
// ----------------------------------------------------------------------------
// tblend_pkg
// shared types and constants of the threshold color blend unit
// ----------------------------------------------------------------------------
package tblend_pkg;

  // width of the amount and threshold values (signed Q7.16)
  localparam int unsigned QW = 24;
  // one guard bit for differences of two Q values
  localparam int unsigned DW = QW + 1;

  // configuration register indexes
  localparam logic [1:0] CfgThresholdLow  = 2'd0;
  localparam logic [1:0] CfgThresholdHigh = 2'd1;
  localparam logic [1:0] CfgBlendMode     = 2'd2;

  // which color an item resolves to
  typedef enum logic [1:0] {
    SelFirst  = 2'd0,
    SelSecond = 2'd1,
    SelMix    = 2'd2
  } sel_e;

  // per-stage advance control handed to the datapath units
  typedef struct packed {
    logic en;
  } stage_ctrl_t;

endpackage

/* hw/rtl/tblend_ifs.sv */
// ----------------------------------------------------------------------------
// tblend_ifs
// valid/ready channels of the threshold color blend unit
// ----------------------------------------------------------------------------
interface tblend_in_if #(
  parameter int unsigned ChanW = 16
);
  logic                         valid;
  logic                         ready;
  logic [tblend_pkg::QW-1:0]    blend_amount;
  logic [ChanW-1:0]             first_red;
  logic [ChanW-1:0]             first_green;
  logic [ChanW-1:0]             first_blue;
  logic [ChanW-1:0]             second_red;
  logic [ChanW-1:0]             second_green;
  logic [ChanW-1:0]             second_blue;

  modport source (
    output valid, blend_amount, first_red, first_green, first_blue,
           second_red, second_green, second_blue,
    input  ready
  );
  modport sink (
    input  valid, blend_amount, first_red, first_green, first_blue,
           second_red, second_green, second_blue,
    output ready
  );
endinterface

interface tblend_out_if #(
  parameter int unsigned ChanW = 16
);
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] mixed_red;
  logic [ChanW-1:0] mixed_green;
  logic [ChanW-1:0] mixed_blue;
  logic             thresholds_invalid;

  modport source (
    output valid, mixed_red, mixed_green, mixed_blue, thresholds_invalid,
    input  ready
  );
  modport sink (
    input  valid, mixed_red, mixed_green, mixed_blue, thresholds_invalid,
    output ready
  );
endinterface

/* hw/rtl/tblend_div.sv */
// ----------------------------------------------------------------------------
// tblend_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tblend_div #(
  parameter int unsigned W = 16
) (
  input  logic                        clk_i,
  input  tblend_pkg::stage_ctrl_t     ctrl_i,
  input  logic [tblend_pkg::DW-1:0]   num_i,
  input  logic [tblend_pkg::DW-1:0]   den_i,
  output logic [W-1:0]                quo_o
);

  localparam int unsigned RW = tblend_pkg::DW + 1;

  logic [RW-1:0]               rem_q [W+1];
  logic [tblend_pkg::DW-1:0]   den_q [W+1];
  logic [W-1:0]                quo_q [W+1];

  assign rem_q[0] = {1'b0, num_i};
  assign den_q[0] = den_i;
  assign quo_q[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [RW-1:0] shl;
    logic [RW-1:0] dext;
    logic          take;
    assign shl  = {rem_q[k][RW-2:0], 1'b0};
    assign dext = {1'b0, den_q[k]};
    assign take = (shl >= dext);
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q[k+1] <= take ? (shl - dext) : shl;
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][W-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[W];

endmodule

/* hw/rtl/tblend_smooth.sv */
// ----------------------------------------------------------------------------
// tblend_smooth
// three-stage weight shaper: linear pass or cubic smoothstep t*t*(3-2t)
// ----------------------------------------------------------------------------
module tblend_smooth #(
  parameter int unsigned W = 16
) (
  input  logic                    clk_i,
  input  tblend_pkg::stage_ctrl_t ctrl_i,
  input  logic [W-1:0]            t_i,
  input  logic                    cubic_i,
  output logic [W-1:0]            w_o
);

  localparam logic [W+2:0]   Half3  = (W+3)'(1) << (W-1);
  localparam logic [2*W+2:0] HalfP  = (2*W+3)'(1) << (W-1);
  localparam logic [W+1:0]   Three1 = (W+2)'(3) << W;
  localparam logic [W+2:0]   MaxW   = (W+3)'((1 << W) - 1);

  logic [2*W-1:0] sq_q;
  logic [W-1:0]   t1_q, t2_q;
  logic           m1_q, m2_q;
  logic [2*W+2:0] prod_q;
  logic [W-1:0]   w_q;

  logic [W:0]     u;
  logic [W+1:0]   f;
  logic [W+2:0]   s;

  // round t*t to Q0.W, then 3 - 2t
  assign u = (W+1)'(({3'b0, sq_q} + Half3) >> W);
  assign f = Three1 - {1'b0, t1_q, 1'b0};
  assign s = (W+3)'((prod_q + HalfP) >> W);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sq_q   <= t_i * t_i;
      t1_q   <= t_i;
      m1_q   <= cubic_i;
      prod_q <= (2*W+3)'(u) * (2*W+3)'(f);
      t2_q   <= t1_q;
      m2_q   <= m1_q;
      w_q    <= m2_q ? ((s > MaxW) ? MaxW[W-1:0] : s[W-1:0]) : t2_q;
    end
  end

  assign w_o = w_q;

endmodule

/* hw/rtl/tblend_mix.sv */
// ----------------------------------------------------------------------------
// tblend_mix
// two-stage channel interpolator a*(1-w) + b*w with round and saturate
// ----------------------------------------------------------------------------
module tblend_mix #(
  parameter int unsigned C = 16,
  parameter int unsigned W = 16
) (
  input  logic                    clk_i,
  input  tblend_pkg::stage_ctrl_t ctrl_i,
  input  logic [C-1:0]            a_i,
  input  logic [C-1:0]            b_i,
  input  logic [W:0]              w_i,
  output logic [C-1:0]            y_o
);

  localparam logic [W:0]     One  = (W+1)'(1) << W;
  localparam logic [C+W+1:0] Half = (C+W+2)'(1) << (W-1);
  localparam logic [C+1:0]   MaxC = (C+2)'((64'(1) << C) - 64'(1));

  logic [C+W:0]   pa_q, pb_q;
  logic [C-1:0]   y_q;
  logic [C+W+1:0] acc;
  logic [C+1:0]   r;

  assign acc = {1'b0, pa_q} + {1'b0, pb_q} + Half;
  assign r   = (C+2)'(acc >> W);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      pa_q <= (C+W+1)'(a_i) * (C+W+1)'(One - w_i);
      pb_q <= (C+W+1)'(b_i) * (C+W+1)'(w_i);
      y_q  <= (r > MaxC) ? MaxC[C-1:0] : r[C-1:0];
    end
  end

  assign y_o = y_q;

endmodule

/* hw/rtl/threshold_color_blend_unit.sv */
// ----------------------------------------------------------------------------
// threshold_color_blend_unit
// threshold-controlled linear or smoothstep blend of two rgb colors
// ----------------------------------------------------------------------------
// One beat in, one beat out, a new beat every clock unless the output stalls.
// Each beat passes through a front stage that compares the amount against
// the thresholds, the pipelined divider that forms (amount - low) /
// (high - low), the smoothstep shaper (used in both modes so latency never
// changes) and the channel mixer, whose last register is the output.
// The whole pipe advances whenever the output register is empty or taken, so
// a stall at the output freezes every stage and nothing is lost or repeated.
// Thresholds and mode are static registers; write them only while idle.
// ----------------------------------------------------------------------------
module threshold_color_blend_unit #(
  parameter int unsigned CHANNEL_BITS     = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tblend_pkg::QW-1:0]  cfg_data_i,
  tblend_in_if.sink                  in_i,
  tblend_out_if.source               out_o
);

  localparam int unsigned C   = CHANNEL_BITS;
  localparam int unsigned W   = WEIGHT_FRAC_BITS;
  localparam int unsigned DW  = tblend_pkg::DW;
  // stages: front compare, divider, shaper, mixer
  localparam int unsigned LAT = W + 6;
  // side data must reach the mixer input, W + 3 stages past the front
  localparam int unsigned SIDE = W + 4;

  typedef struct packed {
    logic [C-1:0]      a_r, a_g, a_b;
    logic [C-1:0]      b_r, b_g, b_b;
    tblend_pkg::sel_e  sel;
    logic              inv;
  } side_t;

  // configuration registers
  logic [tblend_pkg::QW-1:0] thr_lo_q, thr_hi_q;
  logic                      mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lo_q <= '0;
      thr_hi_q <= tblend_pkg::QW'(65536);
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tblend_pkg::CfgThresholdLow:  thr_lo_q <= cfg_data_i;
        tblend_pkg::CfgThresholdHigh: thr_hi_q <= cfg_data_i;
        tblend_pkg::CfgBlendMode:     mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being drained
  tblend_pkg::stage_ctrl_t ctrl;
  assign ctrl.en    = !out_o.valid || out_o.ready;
  assign in_i.ready = ctrl.en;

  // valid bits travel alongside the data
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl.en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // front stage: sign-extend, compare, form numerator and denominator
  logic signed [DW-1:0] amt_s, lo_s, hi_s;
  tblend_pkg::sel_e     sel_d;
  side_t                side_d;
  logic [DW-1:0]        num_q, den_q;
  side_t                side_q [SIDE];

  assign amt_s = DW'(signed'(in_i.blend_amount));
  assign lo_s  = DW'(signed'(thr_lo_q));
  assign hi_s  = DW'(signed'(thr_hi_q));

  always_comb begin
    priority if (amt_s <= lo_s) begin
      sel_d = tblend_pkg::SelFirst;
    end else if (amt_s >= hi_s) begin
      sel_d = tblend_pkg::SelSecond;
    end else begin
      sel_d = tblend_pkg::SelMix;
    end
    side_d.a_r = in_i.first_red;
    side_d.a_g = in_i.first_green;
    side_d.a_b = in_i.first_blue;
    side_d.b_r = in_i.second_red;
    side_d.b_g = in_i.second_green;
    side_d.b_b = in_i.second_blue;
    side_d.sel = sel_d;
    side_d.inv = (hi_s < lo_s);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      num_q     <= amt_s - lo_s;
      den_q     <= hi_s - lo_s;
      side_q[0] <= side_d;
    end
  end

  // colors and selection ride a delay line matched to divider plus shaper
  for (genvar k = 1; k < SIDE; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (ctrl.en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // the user must keep mode static while items are in flight (not enforced here), so it enters at the shaper
  logic [W-1:0] quo, wsh;
  logic [W:0]   wmix;

  tblend_div #(.W(W)) u_div (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .num_i  (num_q),
    .den_i  (den_q),
    .quo_o  (quo)
  );

  tblend_smooth #(.W(W)) u_smooth (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .t_i     (quo),
    .cubic_i (mode_q),
    .w_o     (wsh)
  );

  // at or beyond the thresholds the weight is forced to zero or exactly one
  always_comb begin
    unique case (side_q[SIDE-1].sel)
      tblend_pkg::SelFirst:  wmix = '0;
      tblend_pkg::SelSecond: wmix = (W+1)'(1) << W;
      default:               wmix = {1'b0, wsh};
    endcase
  end

  tblend_mix #(.C(C), .W(W)) u_mix_r (
    .clk_i (clk_i), .ctrl_i (ctrl),
    .a_i (side_q[SIDE-1].a_r), .b_i (side_q[SIDE-1].b_r), .w_i (wmix),
    .y_o (out_o.mixed_red)
  );
  tblend_mix #(.C(C), .W(W)) u_mix_g (
    .clk_i (clk_i), .ctrl_i (ctrl),
    .a_i (side_q[SIDE-1].a_g), .b_i (side_q[SIDE-1].b_g), .w_i (wmix),
    .y_o (out_o.mixed_green)
  );
  tblend_mix #(.C(C), .W(W)) u_mix_b (
    .clk_i (clk_i), .ctrl_i (ctrl),
    .a_i (side_q[SIDE-1].a_b), .b_i (side_q[SIDE-1].b_b), .w_i (wmix),
    .y_o (out_o.mixed_blue)
  );

  // status flag follows the mixer's two stages
  logic [1:0] inv_q;
  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      inv_q <= {inv_q[0], side_q[SIDE-1].inv};
    end
  end

  assign out_o.thresholds_invalid = inv_q[1];
  assign out_o.valid              = vld_q[LAT-1];

`ifndef SYNTHESIS
  // a stall must freeze the whole valid chain
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.en |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  // an accepted beat occupies the front stage next cycle
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted beat lost at front stage");

  // a beat in the last stage before the output register reaches it when the pipe advances
  a_drain_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-2] && ctrl.en |=> out_o.valid)
    else $error("beat dropped before output register");
`endif

endmodule

/* tb/threshold_color_blend_unit_tb.sv */
// ----------------------------------------------------------------------------
// threshold_color_blend_unit_tb
// self-checking bench for the threshold color blend unit
// ----------------------------------------------------------------------------
// Beats are queued by a stimulus process, driven by a clocked driver and
// compared by a clocked monitor against a fixed-point predictor of the
// blend. The run walks through several threshold and mode settings, written
// only while the pipe is drained.
// ----------------------------------------------------------------------------
module threshold_color_blend_unit_tb;

  localparam int unsigned QW = tblend_pkg::QW;
  localparam int unsigned CW = 16;
  localparam int unsigned WF = 16;
  localparam int unsigned PIPE_CYCLES = WF + 6;
  localparam int unsigned STALL_LIMIT = 2000;

  // register settings per phase: low, high
  localparam logic [QW-1:0] LOWS [6] = '{24'h000000, 24'h800000, 24'hFF0000, 24'h010000,
                                         24'h7FFFFF, 24'h123456};
  localparam logic [QW-1:0] HIGHS[6] = '{24'h010000, 24'h7FFFFF, 24'h000100, 24'h010000,
                                         24'h800000, 24'h123457};

  typedef struct packed {
    logic [QW-1:0] amount;
    logic [CW-1:0] ar, ag, ab, br, bg, bb;
  } sample_t;

  typedef struct packed {
    logic [CW-1:0] r, g, b;
    logic          inverted;
  } pixel_t;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [1:0]    cfg_idx_i;
  logic [QW-1:0] cfg_data_i;

  tblend_in_if  #(.ChanW(CW)) in_ch ();
  tblend_out_if #(.ChanW(CW)) out_ch ();

  threshold_color_blend_unit #(
    .CHANNEL_BITS(CW),
    .WEIGHT_FRAC_BITS(WF)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  // predictor copy of the registers
  logic signed [QW-1:0] low_thr;
  logic signed [QW-1:0] high_thr;
  logic                 cubic_mode;

  sample_t pending_samples[$];
  pixel_t  expected_pixels[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      mismatches;
  int      beats_in;
  int      beats_out;
  int      blend_beats;
  int      quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // weight reshaping by t*t*(3-2t), each product rounded half up
  function automatic logic [63:0] smooth(input logic [63:0] t);
    logic [63:0] u, f, s;
    u = (t * t + (64'd1 << (WF - 1))) >> WF;
    f = 3 * (64'd1 << WF) - 2 * t;
    s = (u * f + (64'd1 << (WF - 1))) >> WF;
    if (s > (64'd1 << WF) - 1) s = (64'd1 << WF) - 1;
    return s;
  endfunction

  function automatic logic [CW-1:0] mix(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                        input logic [63:0] t);
    logic [63:0] acc;
    acc = (64'(a) * ((64'd1 << WF) - t) + 64'(b) * t + (64'd1 << (WF - 1))) >> WF;
    if (acc > 64'hFFFF) acc = 64'hFFFF;
    return acc[CW-1:0];
  endfunction

  function automatic pixel_t blend_pixel(input sample_t s);
    pixel_t p;
    logic signed [63:0] amt, lo, hi;
    logic [63:0] t;
    amt = 64'(signed'(s.amount));
    lo  = 64'(low_thr);
    hi  = 64'(high_thr);
    if (amt <= lo) begin
      p.r = s.ar; p.g = s.ag; p.b = s.ab;
    end else if (amt >= hi) begin
      p.r = s.br; p.g = s.bg; p.b = s.bb;
    end else begin
      t = ((amt - lo) << WF) / (hi - lo);
      if (t > (64'd1 << WF) - 1) t = (64'd1 << WF) - 1;
      if (cubic_mode) t = smooth(t);
      p.r = mix(s.ar, s.br, t);
      p.g = mix(s.ag, s.bg, t);
      p.b = mix(s.ab, s.bb, t);
    end
    p.inverted = (hi < lo);
    return p;
  endfunction

  // driver: valid updated by nonblocking assignment, held while a beat waits for ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_pixels.push_back(blend_pixel({in_ch.blend_amount, in_ch.first_red,
          in_ch.first_green, in_ch.first_blue, in_ch.second_red, in_ch.second_green,
          in_ch.second_blue}));
        beats_in++;
        void'(pending_samples.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current beat
      end else if (pending_samples.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        {in_ch.blend_amount, in_ch.first_red, in_ch.first_green, in_ch.first_blue,
         in_ch.second_red, in_ch.second_green, in_ch.second_blue} <= pending_samples[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.mixed_red, out_ch.mixed_green, out_ch.mixed_blue,
               out_ch.thresholds_invalid};
        beats_out++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected r=%h g=%h b=%h inv=%b, got r=%h g=%h b=%h inv=%b",
                       want.r, want.g, want.b, want.inverted,
                       got.r, got.g, got.b, got.inverted);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      // watchdog on handshake activity
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (pending_samples.size() == 0 && expected_pixels.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog expired, %0d beats outstanding", expected_pixels.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [QW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tblend_pkg::CfgThresholdLow:  low_thr = value;
      tblend_pkg::CfgThresholdHigh: high_thr = value;
      tblend_pkg::CfgBlendMode:     cubic_mode = value[0];
      default: ;
    endcase
  endtask

  // let the queue and the pipe drain fully before touching registers
  task automatic drain();
    while (pending_samples.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES + 4) @(posedge clk_i);
  endtask

  task automatic queue_sample(input logic [QW-1:0] amt, input logic [CW-1:0] ar,
                              input logic [CW-1:0] ag, input logic [CW-1:0] ab,
                              input logic [CW-1:0] br, input logic [CW-1:0] bg,
                              input logic [CW-1:0] bb);
    pending_samples.push_back({amt, ar, ag, ab, br, bg, bb});
    if ($signed(amt) > low_thr && $signed(amt) < high_thr) blend_beats++;
  endtask

  function automatic logic [CW-1:0] rand_chan();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  // amounts cluster at and between the thresholds to aim beats at the blend band
  function automatic logic [QW-1:0] rand_amount();
    logic signed [31:0] span;
    case ($urandom_range(9))
      0: return QW'($urandom);
      1: return low_thr;
      2: return high_thr;
      3: return QW'(low_thr + 1);
      4: return QW'(high_thr - 1);
      default: begin
        span = 32'(high_thr) - 32'(low_thr);
        if (span <= 1) return QW'($urandom);
        return QW'(32'(low_thr) + 32'($urandom_range(span)));
      end
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++)
      queue_sample(rand_amount(), rand_chan(), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tblend_pkg::CfgThresholdLow;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    {in_ch.blend_amount, in_ch.first_red, in_ch.first_green, in_ch.first_blue,
     in_ch.second_red, in_ch.second_green, in_ch.second_blue} = '0;
    out_ch.ready = 1'b0;
    low_thr = '0;
    high_thr = QW'(65536);
    cubic_mode = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 55;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    blend_beats = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset thresholds, field extremes, both ends and the middle
    queue_sample(24'h800000, '0, '1, 16'h1234, '1, '0, 16'hABCD);
    queue_sample(24'h000000, '1, '1, '1, '0, '0, '0);
    queue_sample(24'h000001, '0, '0, '0, '1, '1, '1);
    queue_sample(24'h008000, '0, '1, 16'h8000, '1, '0, 16'h7FFF);
    queue_sample(24'h00FFFF, '1, '0, '0, '0, '1, '1);
    queue_sample(24'h010000, '0, '0, '0, '1, '1, '1);
    queue_sample(24'h7FFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA, 16'h5555, 16'hFFFE);
    drain();
    write_reg(tblend_pkg::CfgBlendMode, QW'(1));
    queue_sample(24'h004000, '0, '1, 16'h0100, '1, '0, 16'hFF00);
    queue_sample(24'h008000, '0, '1, 16'h0100, '1, '0, 16'hFF00);
    queue_sample(24'h00C000, '1, '1, '1, '0, '0, '0);
    queue_sample(24'h00FFFF, '0, '0, '0, '1, '1, '1);
    queue_sample(24'h000001, '0, '0, '0, '1, '1, '1);
    drain();
    // inverted thresholds, then equal thresholds
    write_reg(tblend_pkg::CfgThresholdLow, QW'(65536));
    write_reg(tblend_pkg::CfgThresholdHigh, '0);
    queue_sample(24'h008000, '1, '0, '1, '0, '1, '0);
    queue_sample(24'h010000, '1, '0, '1, '0, '1, '0);
    queue_sample(24'h010001, '1, '0, '1, '0, '1, '0);
    drain();
    write_reg(tblend_pkg::CfgThresholdHigh, QW'(65536));
    queue_sample(24'h010000, '1, '0, '1, '0, '1, '0);
    queue_sample(24'h010001, '1, '0, '1, '0, '1, '0);
    queue_sample(24'hFFFFFF, '1, '0, '1, '0, '1, '0);
    drain();

    // random phases across settings and idling profiles
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 17 : (ph < 8) ? 55 : 0;
      recv_idle_pct = (ph < 4) ? 55 : (ph < 8) ? 17 : 0;
      write_reg(tblend_pkg::CfgThresholdLow, LOWS[ph % 6]);
      write_reg(tblend_pkg::CfgThresholdHigh, HIGHS[ph % 6]);
      write_reg(tblend_pkg::CfgBlendMode, QW'(ph % 2));
      random_phase(90);
      drain();
    end

    $display("covered %0d beats in, %0d out, %0d inside the blend band",
             beats_in, beats_out, blend_beats);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
